// ----- design/pis_pkg.sv -----
// ----------------------------------------------------------------------------
// pis_pkg
// Types and constants shared by the permutation inverse block and its testbench.
// ----------------------------------------------------------------------------
package pis_pkg;

    // field widths
    localparam int IW = 10;   // position / image width
    localparam int LW = 11;   // length register width
    localparam int SW = 7;    // skip interval width
    localparam int TW = 13;   // inverse step counter width

    // operation codes
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_BUILD = 2'd1;
    localparam logic [1:0] OP_FWD   = 2'd2;
    localparam logic [1:0] OP_INV   = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_LENGTH = 2'd0;
    localparam logic [1:0] REG_SKIP   = 2'd1;

    // one entry of the shortcut memory
    typedef struct packed {
        logic          flag;
        logic          visited;
        logic [IW-1:0] target;
    } t_mark;

    typedef enum logic [3:0] {
        ST_RST_CLR,
        ST_IDLE,
        ST_FWD,
        ST_INV,
        ST_BLD_CLR,
        ST_BLD_SCAN,
        ST_BLD_SCHK,
        ST_BLD_RD,
        ST_BLD_NXT,
        ST_BLD_VIS,
        ST_BLD_FIN
    } t_state;

endpackage

// ----- design/pis_ram.sv -----
// ----------------------------------------------------------------------------
// pis_ram
// Simple dual-port synchronous RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module pis_ram #(
    parameter int DW = 10,
    parameter int AW = 10
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] mem [2**AW];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= mem[i_raddr];
    end

endmodule

// ----- design/permutation_inverse_shortcut.sv -----
// ----------------------------------------------------------------------------
// permutation_inverse_shortcut
// Permutation store with forward lookup and inverse lookup via shortcut pointers.
// ----------------------------------------------------------------------------
// Usage: drive i_op/i_index/i_value with i_start high; the command word is taken
// at a clock edge where o_busy is low. Exactly one result word follows, shown for
// one cycle with o_done high on o_answer/o_status; the receiver cannot stall it.
// Registers (length_in_use, skip_interval) are written on the config channel
// (i_cfg_valid/o_cfg_ready, always ready); the user must write them only while
// no command is in flight, which the block itself does not enforce.
// Steps, one command at a time:
//   write:   the result word is registered on the accepting edge
//   forward: one permutation memory read, then the result register
//   inverse: a memory read loop, one walk step per cycle; about
//            2*skip_interval steps after a build on a true permutation
//   build:   clear the shortcut memory, then scan each position, walk each new cycle and close it
// After reset the block holds o_busy while it clears the shortcut memory (DEPTH =
// min(MAX_LENGTH, 1024) entries); config writes are still taken.
// ----------------------------------------------------------------------------
module permutation_inverse_shortcut #(
    parameter int MAX_LENGTH = 1024
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    output logic                    o_busy,
    input  logic [1:0]              i_op,
    input  logic [pis_pkg::IW-1:0]  i_index,
    input  logic [pis_pkg::IW-1:0]  i_value,
    output logic                    o_done,
    output logic [pis_pkg::IW-1:0]  o_answer,
    output logic                    o_status,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [1:0]              i_cfg_index,
    input  logic [pis_pkg::LW-1:0]  i_cfg_data
);

    localparam int DEPTH = (MAX_LENGTH > 1024) ? 1024 : MAX_LENGTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int MW    = $bits(pis_pkg::t_mark);
    localparam logic [pis_pkg::LW-1:0] LEN_CAP =
        pis_pkg::LW'((MAX_LENGTH > 2047) ? 2047 : MAX_LENGTH);

    pis_pkg::t_state r_state, n_state;

    logic [pis_pkg::LW-1:0] r_len;
    logic [pis_pkg::SW-1:0] r_skip;
    logic [AW-1:0]          r_clr,    n_clr;
    logic [pis_pkg::LW-1:0] r_start,  n_start;
    logic [pis_pkg::IW-1:0] r_pos,    n_pos;
    logic [pis_pkg::IW-1:0] r_nxt,    n_nxt;
    logic [pis_pkg::IW-1:0] r_last,   n_last;
    logic [pis_pkg::SW-1:0] r_count,  n_count;
    logic                   r_marked, n_marked;
    logic [pis_pkg::IW-1:0] r_query,  n_query;
    logic [pis_pkg::TW-1:0] r_steps,  n_steps;
    logic                   r_jumped, n_jumped;
    logic                   r_done,   n_done;
    logic [pis_pkg::IW-1:0] r_answer, n_answer;
    logic                   r_status, n_status;

    // memory ports
    logic                   p_we;
    logic [AW-1:0]          p_waddr, p_raddr;
    logic [pis_pkg::IW-1:0] p_wdata, p_rdata;
    logic                   m_we;
    logic [AW-1:0]          m_waddr, m_raddr;
    pis_pkg::t_mark         m_wdata, m_rdata;
    logic [MW-1:0]          m_rbits;

    pis_ram #(.DW(pis_pkg::IW), .AW(AW)) u_perm (
        .i_clk   (i_clk),
        .i_we    (p_we),
        .i_waddr (p_waddr),
        .i_wdata (p_wdata),
        .i_raddr (p_raddr),
        .o_rdata (p_rdata)
    );

    pis_ram #(.DW(MW), .AW(AW)) u_mark (
        .i_clk   (i_clk),
        .i_we    (m_we),
        .i_waddr (m_waddr),
        .i_wdata (m_wdata),
        .i_raddr (m_raddr),
        .o_rdata (m_rbits)
    );
    assign m_rdata = pis_pkg::t_mark'(m_rbits);

    // effective length and step
    logic [pis_pkg::LW-1:0] len;
    logic [pis_pkg::SW-1:0] step;
    logic [pis_pkg::TW-1:0] step_limit;
    assign len  = (r_len == '0) ? pis_pkg::LW'(1) : ((r_len > LEN_CAP) ? LEN_CAP : r_len);
    assign step = (r_skip == '0) ? pis_pkg::SW'(1) : r_skip;
    assign step_limit = pis_pkg::TW'({len, 1'b0}) + pis_pkg::TW'(2);

    // shared conditions
    logic                   accept, idx_ok, val_ok, clr_last, start_end;
    logic [pis_pkg::LW-1:0] start_nx;
    logic                   nxt_stop, vis_stop;
    logic                   inv_hit, inv_fail;
    logic [pis_pkg::IW-1:0] inv_pos;
    logic [pis_pkg::SW-1:0] count_nx;

    assign accept    = i_start && !o_busy;
    assign idx_ok    = {1'b0, i_index} < len;
    assign val_ok    = {1'b0, i_value} < len;
    assign clr_last  = (r_clr == AW'(DEPTH - 1));
    assign start_nx  = r_start + pis_pkg::LW'(1);
    assign start_end = (start_nx == len);
    assign nxt_stop  = ({1'b0, p_rdata} == r_start) || ({1'b0, p_rdata} >= len);
    assign vis_stop  = m_rdata.visited || (r_nxt == r_pos);
    assign count_nx  = r_count + pis_pkg::SW'(1);
    assign inv_hit   = (p_rdata == r_query);
    assign inv_pos   = (!r_jumped && m_rdata.flag) ? m_rdata.target : p_rdata;
    assign inv_fail  = ({1'b0, inv_pos} >= len) || (r_steps == step_limit);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pis_pkg::ST_RST_CLR: if (clr_last) n_state = pis_pkg::ST_IDLE;
            pis_pkg::ST_IDLE: begin
                if (accept) begin
                    case (i_op)
                        pis_pkg::OP_BUILD: n_state = pis_pkg::ST_BLD_CLR;
                        pis_pkg::OP_FWD:   if (idx_ok) n_state = pis_pkg::ST_FWD;
                        pis_pkg::OP_INV:   if (idx_ok) n_state = pis_pkg::ST_INV;
                        default:           n_state = pis_pkg::ST_IDLE;
                    endcase
                end
            end
            pis_pkg::ST_FWD: n_state = pis_pkg::ST_IDLE;
            pis_pkg::ST_INV: if (inv_hit || inv_fail) n_state = pis_pkg::ST_IDLE;
            pis_pkg::ST_BLD_CLR: if (clr_last) n_state = pis_pkg::ST_BLD_SCAN;
            pis_pkg::ST_BLD_SCAN: n_state = pis_pkg::ST_BLD_SCHK;
            pis_pkg::ST_BLD_SCHK: begin
                if (!m_rdata.visited) n_state = pis_pkg::ST_BLD_RD;
                else if (start_end)   n_state = pis_pkg::ST_IDLE;
                else                  n_state = pis_pkg::ST_BLD_SCAN;
            end
            pis_pkg::ST_BLD_RD: n_state = pis_pkg::ST_BLD_NXT;
            pis_pkg::ST_BLD_NXT: n_state = nxt_stop ? pis_pkg::ST_BLD_FIN : pis_pkg::ST_BLD_VIS;
            pis_pkg::ST_BLD_VIS: n_state = vis_stop ? pis_pkg::ST_BLD_FIN : pis_pkg::ST_BLD_RD;
            pis_pkg::ST_BLD_FIN: n_state = start_end ? pis_pkg::ST_IDLE : pis_pkg::ST_BLD_SCAN;
            default: n_state = pis_pkg::ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_clr    = r_clr;
        n_start  = r_start;
        n_pos    = r_pos;
        n_nxt    = r_nxt;
        n_last   = r_last;
        n_count  = r_count;
        n_marked = r_marked;
        n_query  = r_query;
        n_steps  = r_steps;
        n_jumped = r_jumped;
        n_done   = 1'b0;
        n_answer = '0;
        n_status = 1'b0;
        p_we     = 1'b0;
        p_waddr  = i_index[AW-1:0];
        p_wdata  = i_value;
        p_raddr  = i_index[AW-1:0];
        m_we     = 1'b0;
        m_waddr  = r_clr;
        m_wdata  = '0;
        m_raddr  = i_index[AW-1:0];
        unique case (r_state)
            pis_pkg::ST_RST_CLR, pis_pkg::ST_BLD_CLR: begin
                // sweep: clear flag and visited bits
                m_we    = 1'b1;
                n_clr   = r_clr + AW'(1);
                n_start = '0;
            end
            pis_pkg::ST_IDLE: begin
                n_steps  = '0;
                n_jumped = 1'b0;
                n_query  = i_index;
                n_pos    = i_index;
                n_clr    = '0;
                if (accept) begin
                    case (i_op)
                        pis_pkg::OP_WRITE: begin
                            p_we     = idx_ok && val_ok;
                            n_done   = 1'b1;
                            n_status = !(idx_ok && val_ok);
                        end
                        pis_pkg::OP_FWD, pis_pkg::OP_INV: begin
                            if (!idx_ok) begin
                                n_done   = 1'b1;
                                n_status = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            pis_pkg::ST_FWD: begin
                n_done = 1'b1;
                if ({1'b0, p_rdata} < len) n_answer = p_rdata;
                else                       n_status = 1'b1;
            end
            pis_pkg::ST_INV: begin
                // one walk step per cycle; take the first shortcut met
                n_pos    = inv_pos;
                n_steps  = r_steps + pis_pkg::TW'(1);
                if (!r_jumped && m_rdata.flag) n_jumped = 1'b1;
                p_raddr  = inv_pos[AW-1:0];
                m_raddr  = inv_pos[AW-1:0];
                if (inv_hit) begin
                    n_done   = 1'b1;
                    n_answer = r_pos;
                end else if (inv_fail) begin
                    n_done   = 1'b1;
                    n_status = 1'b1;
                end
            end
            pis_pkg::ST_BLD_SCAN: begin
                m_raddr = r_start[AW-1:0];
            end
            pis_pkg::ST_BLD_SCHK: begin
                n_pos    = r_start[pis_pkg::IW-1:0];
                n_last   = r_start[pis_pkg::IW-1:0];
                n_count  = '0;
                n_marked = 1'b0;
                if (m_rdata.visited) begin
                    n_start = start_nx;
                    n_done  = start_end;
                end
            end
            pis_pkg::ST_BLD_RD: begin
                p_raddr = r_pos[AW-1:0];
            end
            pis_pkg::ST_BLD_NXT: begin
                // mark current position visited, maybe place a back pointer
                n_nxt          = p_rdata;
                m_we           = 1'b1;
                m_waddr        = r_pos[AW-1:0];
                m_wdata.flag   = 1'b0;
                m_wdata.visited = 1'b1;
                m_wdata.target = r_last;
                m_raddr        = p_rdata[AW-1:0];
                if ({1'b0, p_rdata} != r_start) begin
                    if (count_nx == step) begin
                        m_wdata.flag = 1'b1;
                        n_count  = '0;
                        n_marked = 1'b1;
                        n_last   = r_pos;
                    end else begin
                        n_count = count_nx;
                    end
                end
            end
            pis_pkg::ST_BLD_VIS: begin
                if (!vis_stop) n_pos = r_nxt;
            end
            pis_pkg::ST_BLD_FIN: begin
                // close the cycle: start points to its last mark
                m_we            = r_marked;
                m_waddr         = r_start[AW-1:0];
                m_wdata.flag    = 1'b1;
                m_wdata.visited = 1'b1;
                m_wdata.target  = r_last;
                n_start         = start_nx;
                n_done          = start_end;
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= pis_pkg::ST_RST_CLR;
            r_clr    <= '0;
            r_done   <= 1'b0;
            r_len    <= pis_pkg::LW'(1024);
            r_skip   <= pis_pkg::SW'(4);
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_done   <= n_done;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    pis_pkg::REG_LENGTH: r_len  <= i_cfg_data;
                    pis_pkg::REG_SKIP:   r_skip <= i_cfg_data[pis_pkg::SW-1:0];
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_start  <= n_start;
        r_pos    <= n_pos;
        r_nxt    <= n_nxt;
        r_last   <= n_last;
        r_count  <= n_count;
        r_marked <= n_marked;
        r_query  <= n_query;
        r_steps  <= n_steps;
        r_jumped <= n_jumped;
        r_answer <= n_answer;
        r_status <= n_status;
    end

    assign o_busy      = (r_state != pis_pkg::ST_IDLE);
    assign o_done      = r_done;
    assign o_answer    = r_answer;
    assign o_status    = r_status;
    assign o_cfg_ready = 1'b1;

`ifndef SYNTHESIS
    // out-of-range write reports an error on the next word
    a_write_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_op == pis_pkg::OP_WRITE && !idx_ok) |=> (o_done && o_status))
        else $error("out-of-range write not flagged");

    // an error word carries a zero answer
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status) |-> (o_answer == '0))
        else $error("error word with nonzero answer");

    // a good answer lies inside the table
    a_ans_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_status) |-> ({1'b0, o_answer} < len))
        else $error("answer outside length in use");
`endif

endmodule

// ----- bench/pis_scoreboard.sv -----
// ----------------------------------------------------------------------------
// pis_scoreboard
// Watches the command, result and register channels of the permutation
// inverse block. It keeps its own copy of the table and the shortcut marks,
// predicts the result word of every accepted command and compares each
// result word with the oldest prediction.
// ----------------------------------------------------------------------------
module pis_scoreboard (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic                   i_busy,
    input  logic [1:0]             i_op,
    input  logic [pis_pkg::IW-1:0] i_index,
    input  logic [pis_pkg::IW-1:0] i_value,
    input  logic                   i_done,
    input  logic [pis_pkg::IW-1:0] i_answer,
    input  logic                   i_status,
    input  logic                   i_cfg_valid,
    input  logic                   i_cfg_ready,
    input  logic [1:0]             i_cfg_index,
    input  logic [pis_pkg::LW-1:0] i_cfg_data,
    output int                     o_fail_count,
    output int                     o_pending
);

    typedef struct packed {
        logic [pis_pkg::IW-1:0] answer;
        logic                   status;
    } t_result;

    localparam int DEPTH = 1024;

    logic [pis_pkg::IW-1:0] perm_copy   [DEPTH];
    logic                   mark_flag   [DEPTH];
    logic [pis_pkg::IW-1:0] mark_target [DEPTH];
    logic                   seen        [DEPTH];
    logic [pis_pkg::LW-1:0] length_reg;
    logic [pis_pkg::SW-1:0] skip_reg;

    t_result result_queue [$];

    // Mismatch or stray word: print one line and count it
    task automatic report(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        o_fail_count = o_fail_count + 1;
    endtask

    function automatic int live_length();
        if (length_reg == 0) return 1;
        if (length_reg > DEPTH) return DEPTH;
        return int'(length_reg);
    endfunction

    // Walk every cycle and lay down back pointers every skip steps
    function automatic void lay_shortcuts();
        int len;
        int stride;
        int pos;
        int count;
        int last;
        int marks;
        int nxt;
        len = live_length();
        stride = (skip_reg == 0) ? 1 : int'(skip_reg);
        for (int i = 0; i < DEPTH; i++) begin
            seen[i] = 1'b0;
            mark_flag[i] = 1'b0;
        end
        for (int s = 0; s < len; s++) begin
            if (!seen[s]) begin
                pos = s;
                count = 0;
                last = s;
                marks = 0;
                forever begin
                    seen[pos] = 1'b1;
                    nxt = int'(perm_copy[pos]);
                    if (nxt == s) break;
                    count++;
                    if (count == stride) begin
                        count = 0;
                        marks++;
                        mark_flag[pos] = 1'b1;
                        mark_target[pos] = pis_pkg::IW'(last);
                        last = pos;
                    end
                    if (nxt >= len || seen[nxt]) break;
                    pos = nxt;
                end
                if (marks > 0) begin
                    mark_flag[s] = 1'b1;
                    mark_target[s] = pis_pkg::IW'(last);
                end
            end
        end
    endfunction

    // Walk forward from q, taking the first shortcut met
    function automatic void walk_back(input int q, output bit found, output int where);
        int len;
        int pos;
        int nxt;
        bit jumped;
        len = live_length();
        pos = q;
        jumped = 1'b0;
        found = 1'b0;
        where = 0;
        for (int steps = 0; steps <= 2 * len + 2; steps++) begin
            nxt = int'(perm_copy[pos]);
            if (nxt == q) begin
                found = 1'b1;
                where = pos;
                return;
            end
            if (!jumped && mark_flag[pos]) begin
                pos = int'(mark_target[pos]);
                jumped = 1'b1;
            end else begin
                pos = nxt;
            end
            if (pos >= len) return;
        end
    endfunction

    function automatic t_result predict_result(input logic [1:0] op,
                                               input int idx, input int val);
        t_result r;
        int len;
        bit found;
        int where;
        len = live_length();
        r = '0;
        case (op)
            pis_pkg::OP_WRITE: begin
                if (idx < len && val < len) perm_copy[idx] = pis_pkg::IW'(val);
                else r.status = 1'b1;
            end
            pis_pkg::OP_BUILD: begin
                lay_shortcuts();
            end
            pis_pkg::OP_FWD: begin
                if (idx < len && int'(perm_copy[idx]) < len) r.answer = perm_copy[idx];
                else r.status = 1'b1;
            end
            default: begin
                found = 1'b0;
                where = 0;
                if (idx < len) walk_back(idx, found, where);
                if (found) r.answer = pis_pkg::IW'(where);
                else r.status = 1'b1;
            end
        endcase
        return r;
    endfunction

    // Track registers, predict accepted commands, check result words
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                perm_copy[i] = '0;
                mark_flag[i] = 1'b0;
                mark_target[i] = '0;
                seen[i] = 1'b0;
            end
            length_reg = pis_pkg::LW'(1024);
            skip_reg = pis_pkg::SW'(4);
            result_queue.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == pis_pkg::REG_LENGTH) length_reg = i_cfg_data;
                else if (i_cfg_index == pis_pkg::REG_SKIP)
                    skip_reg = i_cfg_data[pis_pkg::SW-1:0];
            end
            if (i_start && !i_busy)
                result_queue.push_back(predict_result(i_op, int'(i_index), int'(i_value)));
            if (i_done) begin
                if (result_queue.size() == 0) begin
                    report($sformatf("result word answer=%0d status=%0d with none expected",
                                     i_answer, i_status));
                end else begin
                    want = result_queue.pop_front();
                    if (i_answer !== want.answer)
                        report($sformatf("answer %0d, expected %0d", i_answer, want.answer));
                    if (i_status !== want.status)
                        report($sformatf("status %0d, expected %0d", i_status, want.status));
                end
            end
        end
        o_pending = result_queue.size();
    end

endmodule

// ----- bench/permutation_inverse_shortcut_tb.sv -----
// ----------------------------------------------------------------------------
// permutation_inverse_shortcut_tb
// Drives the permutation inverse block through phases of register settings:
// the random phases each load a permutation, build shortcuts and then mix forward,
// inverse, write and build commands, with corrupted tables and out-of-range
// indexes. The scoreboard predicts and checks every result word.
// ----------------------------------------------------------------------------
module permutation_inverse_shortcut_tb;

    localparam int WATCH_LIMIT = 60000;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_start;
    logic                   o_busy;
    logic [1:0]             i_op;
    logic [pis_pkg::IW-1:0] i_index;
    logic [pis_pkg::IW-1:0] i_value;
    logic                   o_done;
    logic [pis_pkg::IW-1:0] o_answer;
    logic                   o_status;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [1:0]             i_cfg_index;
    logic [pis_pkg::LW-1:0] i_cfg_data;

    int fail_count;
    int pending;
    int items_sent;
    int op_count [4];
    int phase_count;
    int idle_cycles = 0;
    bit gaps_on;
    int cur_len;

    permutation_inverse_shortcut u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_op(i_op), .i_index(i_index), .i_value(i_value), .o_done(o_done),
        .o_answer(o_answer), .o_status(o_status), .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    pis_scoreboard u_score (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .i_busy(o_busy),
        .i_op(i_op), .i_index(i_index), .i_value(i_value), .i_done(o_done),
        .i_answer(o_answer), .i_status(o_status), .i_cfg_valid(i_cfg_valid),
        .i_cfg_ready(o_cfg_ready), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog: end the run after too many cycles without a handshake
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_done || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCH_LIMIT) begin
            $display("watchdog expired after %0d quiet cycles", idle_cycles);
            $display("permutation_inverse_shortcut test failed");
            $finish;
        end
    end

    // Send one command word; start stays high until a gap or a drain lowers it
    task automatic send_word(input logic [1:0] op, input int idx, input int val);
        i_start <= 1'b1;
        i_op <= op;
        i_index <= pis_pkg::IW'(idx);
        i_value <= pis_pkg::IW'(val);
        do @(posedge i_clk); while (o_busy);
        items_sent++;
        op_count[op]++;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
    endtask

    // Hold off until every expected word has come and the block is idle
    task automatic drain();
        i_start <= 1'b0;
        do @(posedge i_clk); while (pending != 0 || o_busy);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input int data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= pis_pkg::LW'(data);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Set both registers between phases; length register value kept for the driver
    task automatic configure(input int len_data, input int skip_data);
        drain();
        write_reg(pis_pkg::REG_LENGTH, len_data);
        write_reg(pis_pkg::REG_SKIP, skip_data);
        cur_len = (len_data == 0) ? 1 : (len_data > 1024 ? 1024 : len_data);
        phase_count++;
    endtask

    // Load a shuffled permutation of all live entries
    task automatic load_permutation();
        int p [];
        int j;
        int t;
        p = new[cur_len];
        for (int i = 0; i < cur_len; i++) p[i] = i;
        for (int i = cur_len - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = p[i];
            p[i] = p[j];
            p[j] = t;
        end
        for (int i = 0; i < cur_len; i++) send_word(pis_pkg::OP_WRITE, i, p[i]);
    endtask

    // One random command, biased toward in-range lookups
    task automatic random_word();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)      send_word(pis_pkg::OP_INV, $urandom_range(0, cur_len - 1),
                                   $urandom_range(0, 1023));
        else if (r < 70) send_word(pis_pkg::OP_FWD, $urandom_range(0, cur_len - 1),
                                   $urandom_range(0, 1023));
        else if (r < 80) send_word(r[0] ? pis_pkg::OP_INV : pis_pkg::OP_FWD,
                                   $urandom_range(0, 1023), $urandom_range(0, 1023));
        else if (r < 88) send_word(pis_pkg::OP_WRITE, $urandom_range(0, cur_len - 1),
                                   $urandom_range(0, cur_len - 1));
        else if (r < 94) send_word(pis_pkg::OP_BUILD, $urandom_range(0, 1023),
                                   $urandom_range(0, 1023));
        else             send_word(pis_pkg::OP_WRITE, $urandom_range(0, 1023),
                                   $urandom_range(0, 1023));
    endtask

    initial begin
        int random_goal;
        int len_pick;
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_op = pis_pkg::OP_WRITE;
        i_index = '0;
        i_value = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = pis_pkg::REG_LENGTH;
        i_cfg_data = '0;
        items_sent = 0;
        phase_count = 0;
        gaps_on = 1'b1;
        cur_len = 1024;
        for (int i = 0; i < 4; i++) op_count[i] = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: eight entries, interval one marks the start twice
        configure(8, 1);
        for (int i = 0; i < 8; i++) send_word(pis_pkg::OP_WRITE, i, (i + 1) % 8);
        send_word(pis_pkg::OP_WRITE, 1023, 3);
        send_word(pis_pkg::OP_WRITE, 2, 1023);
        send_word(pis_pkg::OP_FWD, 1023, 0);
        send_word(pis_pkg::OP_INV, 1023, 0);
        send_word(pis_pkg::OP_INV, 5, 0);
        send_word(pis_pkg::OP_BUILD, 0, 0);
        send_word(pis_pkg::OP_INV, 0, 0);
        send_word(pis_pkg::OP_INV, 7, 1023);
        send_word(pis_pkg::OP_FWD, 7, 0);
        // Non-permutation: duplicate image, then build and walk
        send_word(pis_pkg::OP_WRITE, 3, 6);
        send_word(pis_pkg::OP_INV, 4, 0);
        send_word(pis_pkg::OP_BUILD, 0, 0);
        send_word(pis_pkg::OP_INV, 6, 0);
        send_word(pis_pkg::OP_INV, 4, 0);
        // Shrink the length: stored images fall out of range; zero length acts as one
        configure(3, 0);
        send_word(pis_pkg::OP_FWD, 2, 0);
        send_word(pis_pkg::OP_INV, 1, 0);
        configure(0, 127);
        send_word(pis_pkg::OP_WRITE, 0, 0);
        send_word(pis_pkg::OP_BUILD, 0, 0);
        send_word(pis_pkg::OP_INV, 0, 0);
        send_word(pis_pkg::OP_FWD, 0, 0);

        // A larger table, then an oversized length register over its loaded part
        configure(256, 11);
        load_permutation();
        send_word(pis_pkg::OP_BUILD, 0, 0);
        for (int k = 0; k < 20; k++) random_word();
        configure(2047, 64);
        for (int k = 0; k < 20; k++)
            send_word(k[0] ? pis_pkg::OP_INV : pis_pkg::OP_FWD, $urandom_range(0, 255), 0);

        // Random phases, mostly short tables; the tail runs without gaps
        random_goal = items_sent + 850;
        while (items_sent < random_goal) begin
            gaps_on = (items_sent < random_goal - 250) && ($urandom_range(0, 3) != 0);
            len_pick = $urandom_range(0, 9) < 7 ? $urandom_range(1, 40)
                                                : $urandom_range(41, 200);
            configure(len_pick, $urandom_range(0, 9) < 8 ? $urandom_range(1, 8)
                                                         : $urandom_range(0, 2047));
            load_permutation();
            if ($urandom_range(0, 3) == 0)
                send_word(pis_pkg::OP_WRITE, $urandom_range(0, cur_len - 1),
                          $urandom_range(0, cur_len - 1));
            send_word(pis_pkg::OP_BUILD, $urandom_range(0, 1023), $urandom_range(0, 1023));
            repeat ($urandom_range(20, 60)) random_word();
        end
        gaps_on = 1'b0;
        drain();
        repeat (20) @(posedge i_clk);

        $display("ran %0d commands over %0d register settings", items_sent, phase_count);
        $display("writes %0d, builds %0d, forward %0d, inverse %0d",
                 op_count[pis_pkg::OP_WRITE], op_count[pis_pkg::OP_BUILD],
                 op_count[pis_pkg::OP_FWD], op_count[pis_pkg::OP_INV]);
        if (fail_count == 0) begin
            $display("permutation_inverse_shortcut test passed");
        end else begin
            $display("permutation_inverse_shortcut test failed");
        end
        $finish;
    end

endmodule
